### src/ps2rx_pkg.sv
`timescale 1ns / 1ps

package ps2rx_pkg;

	localparam int FIFO_DEPTH = 64;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	localparam int CMD_W = 2;
	localparam int BYTE_W = 8;
	localparam int TIMEOUT_W = 10;
	localparam int POS_W = 4;
	localparam int LEVEL_W = 6;
	localparam int LEVEL_MAX = 63;

	localparam logic [CMD_W-1:0] CMD_EDGE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POP = 2'd2;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd100;
	localparam logic [TIMEOUT_W-1:0] IDLE_MAX = 10'd1023;
	localparam logic [POS_W-1:0] FRAME_BITS = 4'd11;
	localparam logic [POS_W-1:0] DATA_BITS = 4'd8;

	typedef struct packed {
		logic done;
		logic [BYTE_W-1:0] data;
	} frame_t;

	typedef struct packed {
		logic stored;
		logic dropped;
		logic popped;
		logic not_empty;
		logic [LEVEL_W-1:0] level;
	} fifo_status_t;

endpackage

### src/ps2rx_if.sv
`timescale 1ns / 1ps

interface ps2rx_in_if;
	logic valid;
	logic ready;
	logic [ps2rx_pkg::CMD_W-1:0] command;
	logic data_bit;

	modport source (output valid, output command, output data_bit, input ready);
	modport sink (input valid, input command, input data_bit, output ready);
endinterface

interface ps2rx_out_if;
	logic valid;
	logic ready;
	logic [ps2rx_pkg::BYTE_W-1:0] scan_code;
	logic code_valid;
	logic frame_stored;
	logic frame_dropped;
	logic fifo_not_empty;
	logic [ps2rx_pkg::LEVEL_W-1:0] fifo_level;

	modport source (output valid, output scan_code, output code_valid, output frame_stored,
		output frame_dropped, output fifo_not_empty, output fifo_level, input ready);
	modport sink (input valid, input scan_code, input code_valid, input frame_stored,
		input frame_dropped, input fifo_not_empty, input fifo_level, output ready);
endinterface

### src/ps2rx_frame.sv
`timescale 1ns / 1ps

module ps2rx_frame (
	input  logic clk,
	input  logic arst_n,
	input  logic edge_req,
	input  logic tick_req,
	input  logic data_bit,
	input  logic cfg_wr_en,
	input  logic [ps2rx_pkg::TIMEOUT_W-1:0] cfg_wr_data,
	output ps2rx_pkg::frame_t frame
);
	import ps2rx_pkg::*;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic [TIMEOUT_W-1:0] idle_q;
	logic [POS_W-1:0] bit_pos_q;
	logic [BYTE_W-1:0] shift_q;

	logic timed_out;
	logic false_start;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] pos_next;
	logic [BYTE_W-1:0] sb;
	logic [BYTE_W-1:0] sb_set;
	logic [2:0] bit_idx;

	always_comb begin
		timed_out = idle_q > timeout_q;
		pos = timed_out ? '0 : bit_pos_q;
		sb = timed_out ? '0 : shift_q;
		false_start = (pos == '0) && data_bit;
		bit_idx = 3'(pos - 1'b1);
		sb_set = sb;
		if (pos >= 4'd1 && pos <= DATA_BITS) begin
			sb_set = sb | (BYTE_W'(data_bit) << bit_idx);
		end
		pos_next = pos + 1'b1;
		frame.done = edge_req && !false_start && (pos_next >= FRAME_BITS);
		frame.data = sb_set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			idle_q <= '0;
			bit_pos_q <= '0;
			shift_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (edge_req) begin
				idle_q <= '0;
				if (false_start) begin
					bit_pos_q <= '0;
					shift_q <= sb;
				end else if (pos_next >= FRAME_BITS) begin
					bit_pos_q <= '0;
					shift_q <= '0;
				end else begin
					bit_pos_q <= pos_next;
					shift_q <= sb_set;
				end
			end else if (tick_req && idle_q != IDLE_MAX) begin
				idle_q <= idle_q + 1'b1;
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_pos_q < FRAME_BITS)
		else $error("bit position beyond frame length");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		edge_req |=> idle_q == '0)
		else $error("idle counter not cleared by edge");

endmodule

### src/ps2rx_fifo.sv
`timescale 1ns / 1ps

module ps2rx_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [ps2rx_pkg::BYTE_W-1:0] push_data,
	input  logic pop,
	output logic [ps2rx_pkg::BYTE_W-1:0] rd_data_q,
	output ps2rx_pkg::fifo_status_t status
);
	import ps2rx_pkg::*;

	logic [BYTE_W-1:0] mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;

	logic [PTR_W-1:0] wr_inc;
	logic [PTR_W-1:0] rd_inc;
	logic [PTR_W-1:0] wr_nxt;
	logic [PTR_W-1:0] rd_nxt;
	logic full;
	logic empty;
	logic do_push;
	logic do_pop;
	logic [CNT_W-1:0] diff;
	logic [CNT_W-1:0] cnt;

	always_comb begin
		wr_inc = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
		rd_inc = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
		full = wr_inc == rd_ptr_q;
		empty = wr_ptr_q == rd_ptr_q;
		do_push = push && !full;
		do_pop = pop && !empty;
		wr_nxt = do_push ? wr_inc : wr_ptr_q;
		rd_nxt = do_pop ? rd_inc : rd_ptr_q;
		diff = {1'b0, wr_nxt} + CNT_W'(FIFO_DEPTH) - {1'b0, rd_nxt};
		cnt = (diff >= CNT_W'(FIFO_DEPTH)) ? diff - CNT_W'(FIFO_DEPTH) : diff;
		status.stored = do_push;
		status.dropped = push && full;
		status.popped = do_pop;
		status.not_empty = cnt != '0;
		status.level = (cnt > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			wr_ptr_q <= wr_nxt;
			rd_ptr_q <= rd_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (do_pop) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	a_drop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(push && full) |=> $stable(wr_ptr_q))
		else $error("write pointer moved on dropped byte");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && empty) |=> $stable(rd_ptr_q))
		else $error("read pointer moved on empty pop");

endmodule

### src/ps2_receive_deserializer_fifo.sv
`timescale 1ns / 1ps
// pipeline: two register stages, s1 holds the accepted request and s2 holds the registered result
// throughput: one request per cycle, stalls only while the result is not taken
// every request gives exactly one result
// reset: asynchronous active low, clears frame state, idle counter and fifo pointers
// timeout register resets to 100, fifo contents are not cleared

module ps2_receive_deserializer_fifo (
	input  logic clk,
	input  logic arst_n,
	ps2rx_in_if.sink in_ch,
	ps2rx_out_if.source out_ch,
	input  logic cfg_wr_en,
	input  logic [ps2rx_pkg::TIMEOUT_W-1:0] cfg_wr_data
);
	import ps2rx_pkg::*;

	logic valid_s1;
	logic [CMD_W-1:0] cmd_s1;
	logic bit_s1;
	logic valid_s2;
	fifo_status_t status_s2;

	logic en;
	logic step;
	frame_t frame;
	fifo_status_t status;
	logic [BYTE_W-1:0] rd_data;

	assign en = !valid_s2 || out_ch.ready;
	assign step = valid_s1 && en;
	assign in_ch.ready = en;

	ps2rx_frame u_frame (
		.clk (clk),
		.arst_n (arst_n),
		.edge_req (step && cmd_s1 == CMD_EDGE),
		.tick_req (step && cmd_s1 == CMD_TICK),
		.data_bit (bit_s1),
		.cfg_wr_en (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.frame (frame)
	);

	ps2rx_fifo u_fifo (
		.clk (clk),
		.arst_n (arst_n),
		.push (frame.done),
		.push_data (frame.data),
		.pop (step && cmd_s1 == CMD_POP),
		.rd_data_q (rd_data),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_ch.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= in_ch.command;
			bit_s1 <= in_ch.data_bit;
			status_s2 <= status;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.scan_code = status_s2.popped ? rd_data : '0;
	assign out_ch.code_valid = status_s2.popped;
	assign out_ch.frame_stored = status_s2.stored;
	assign out_ch.frame_dropped = status_s2.dropped;
	assign out_ch.fifo_not_empty = status_s2.not_empty;
	assign out_ch.fifo_level = status_s2.level;

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $countones({status_s2.popped, status_s2.stored, status_s2.dropped}) <= 1)
		else $error("result reports more than one event");

	a_step_advances: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("request lost between stages");

endmodule
